>>> hw/rtl/cmm_pkg.sv
package cmm_pkg;

	// Field widths
	localparam int CNT_W   = 32;
	localparam int FRAC_W  = 16;
	localparam int MCC_W   = 16;
	localparam int MCC_FRAC = 15;

	// Internal widths, all following from the counter and score widths
	localparam int SCORE_W = FRAC_W + 1;
	localparam int SUM_W   = CNT_W + 2;
	localparam int PAIR_W  = CNT_W + 1;
	localparam int MAG_W   = 2 * CNT_W;
	localparam int PROD_W  = 2 * PAIR_W;
	localparam int DEN_W   = 2 * PROD_W;
	localparam int WORK_W  = DEN_W + 1;
	localparam int SHIFT_W = PROD_W;
	localparam int QUO_W   = 2 * FRAC_W + 1;
	localparam int STEP_W  = $clog2(SHIFT_W + 1);

	localparam logic [SCORE_W-1:0] SCORE_ONE = {1'b1, {FRAC_W{1'b0}}};
	localparam logic [FRAC_W-1:0]  SCORE_HALF = {1'b1, {(FRAC_W-1){1'b0}}};
	localparam logic [FRAC_W-1:0]  THRESHOLD_RESET = SCORE_HALF;
	localparam longint TINY_INT = ((longint'(1) << FRAC_W) + 99999) / 100000;
	localparam logic [SCORE_W:0]   TINY_SUM = (SCORE_W+1)'(TINY_INT);
	localparam logic [MCC_W-1:0]   MCC_MAX = {1'b0, {(MCC_W-1){1'b1}}};

	// Configuration register indexes
	localparam logic CFG_THRESHOLD = 1'b0;
	localparam logic CFG_SCORE_SEL = 1'b1;

	typedef enum logic [1:0] {
		SEL_ACC = 2'd0,
		SEL_F1  = 2'd1,
		SEL_MCC = 2'd2,
		SEL_HS  = 2'd3
	} score_sel_t;

	typedef enum logic [1:0] {
		IT_MUL  = 2'd0,
		IT_DIV  = 2'd1,
		IT_SQRT = 2'd2
	} iter_mode_t;

	// Micro-operations run in this order for every item
	typedef enum logic [3:0] {
		OP_ACC  = 4'd0,
		OP_PREC = 4'd1,
		OP_REC  = 4'd2,
		OP_SPEC = 4'd3,
		OP_F1   = 4'd4,
		OP_RS   = 4'd5,
		OP_HS   = 4'd6,
		OP_AD   = 4'd7,
		OP_BC   = 4'd8,
		OP_P1   = 4'd9,
		OP_P2   = 4'd10,
		OP_DEN  = 4'd11,
		OP_MAG2 = 4'd12,
		OP_X    = 4'd13,
		OP_SQRT = 4'd14
	} op_t;

	localparam op_t OP_FIRST = OP_ACC;
	localparam op_t OP_LAST  = OP_SQRT;

	typedef struct packed {
		logic accept;
		logic start;
		op_t  op;
		logic load;
	} cmm_cmd_t;

	typedef struct packed {
		logic done;
	} cmm_sts_t;

	// Result item, first field in the highest bits
	typedef struct packed {
		logic [FRAC_W-1:0] loss;
		logic [FRAC_W-1:0] sens_spec_score;
		logic [MCC_W-1:0]  mcc;
		logic [FRAC_W-1:0] f1_score;
		logic [FRAC_W-1:0] specificity;
		logic [FRAC_W-1:0] recall;
		logic [FRAC_W-1:0] precision;
		logic [FRAC_W-1:0] accuracy;
		logic [CNT_W-1:0]  true_neg;
		logic [CNT_W-1:0]  false_neg;
		logic [CNT_W-1:0]  false_pos;
		logic [CNT_W-1:0]  true_pos;
	} cmm_result_t;

	// Clamp an unsaturated score to the output range.
	function automatic logic [FRAC_W-1:0] sat_score(logic [SCORE_W:0] v);
		logic [FRAC_W-1:0] r;
		r = (v >= (SCORE_W+1)'(SCORE_ONE)) ? {FRAC_W{1'b1}} : v[FRAC_W-1:0];
		return r;
	endfunction

endpackage

>>> hw/rtl/confusion_matrix_metrics_unit.sv
// Binary confusion-matrix metrics unit.
// The slave stream takes one prediction per transfer, with its optional label;
// the master stream returns one result per item: the four saturating counts,
// accuracy, precision, recall, specificity, F1, MCC, the harmonic
// recall/specificity score and the selected loss. The configuration channel
// writes the decision threshold (index 0) and the loss score select (index 1),
// and is always ready.
// Fifteen micro-operations run one after the other on a single shared
// multiply/divide/square-root unit, then the output register is loaded. The
// 66-step product of the MCC denominator and the 64-step squared numerator
// are the longest of them.
// One item is in work at a time: a new item is not accepted until the last
// one has been loaded into the output register.
// A stalled receiver holds the result in the output register; the next item is
// still accepted and computed, and waits until that register is taken.
// Reset clears the counts, sets the threshold to one half and selects accuracy.
module confusion_matrix_metrics_unit import cmm_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// [15:0] pred_score, [16] pred_bool, [32:17] label_score, [33] label_bool
	input  logic [39:0]  s_axis_tdata,
	// [0] pred_is_bool, [1] label_is_bool, [2] label_present
	input  logic [2:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// true_pos, false_pos, false_neg, true_neg (32 each), then accuracy,
	// precision, recall, specificity, f1_score, mcc, sens_spec_score, loss
	output logic [255:0] m_axis_tdata,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic         cfg_index,
	input  logic [15:0]  cfg_data
);

	cmm_cmd_t    cmd;
	cmm_sts_t    sts;
	cmm_result_t result;
	cmm_result_t out_q;

	cmm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.cmd       (cmd),
		.sts       (sts)
	);

	cmm_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.pred_score    (s_axis_tdata[15:0]),
		.pred_is_bool  (s_axis_tuser[0]),
		.pred_bool     (s_axis_tdata[16]),
		.label_score   (s_axis_tdata[32:17]),
		.label_is_bool (s_axis_tuser[1]),
		.label_bool    (s_axis_tdata[33]),
		.label_present (s_axis_tuser[2]),
		.cfg_write     (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.result        (result)
	);

	// Output register
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			out_q <= result;
		end
	end

	assign cfg_ready    = 1'b1;
	assign m_axis_tdata = out_q;

endmodule

>>> hw/rtl/cmm_iter.sv
module cmm_iter import cmm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  iter_mode_t         mode,
	input  logic [STEP_W-1:0]  steps,
	input  logic [WORK_W-1:0]  w_init,
	input  logic [DEN_W-1:0]   m_init,
	input  logic [SHIFT_W-1:0] s_init,
	output logic               done,
	output logic [WORK_W-1:0]  work,
	output logic [QUO_W-1:0]   quo
);

	logic               busy_q;
	logic               done_q;
	logic [STEP_W-1:0]  cnt_q;
	iter_mode_t         mode_q;
	logic [WORK_W-1:0]  w_q;
	logic [DEN_W-1:0]   m_q;
	logic [SHIFT_W-1:0] s_q;
	logic [QUO_W-1:0]   q_q;

	logic [WORK_W-1:0] rem_shift;
	logic [WORK_W-1:0] divisor;
	logic [WORK_W-1:0] diff;
	logic [WORK_W-1:0] acc_sum;
	logic              fits;

	// One restoring step: division brings in one bit, square root two.
	always_comb begin
		if (mode_q == IT_SQRT) begin
			rem_shift = {w_q[WORK_W-3:0], s_q[SHIFT_W-1 -: 2]};
			divisor   = WORK_W'({q_q, 2'b01});
		end else begin
			rem_shift = {w_q[WORK_W-2:0], s_q[SHIFT_W-1]};
			divisor   = {1'b0, m_q};
		end
		fits    = rem_shift >= divisor;
		diff    = rem_shift - divisor;
		acc_sum = w_q + {1'b0, m_q};
	end

	// Step counter and completion flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == STEP_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - STEP_W'(1);
				if (cnt_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Shift-add multiply, restoring divide and restoring square root
	always_ff @(posedge clk) begin
		if (start) begin
			mode_q <= mode;
			w_q    <= w_init;
			m_q    <= m_init;
			s_q    <= s_init;
			q_q    <= '0;
		end else if (busy_q) begin
			case (mode_q)
				IT_MUL: begin
					if (s_q[0]) begin
						w_q <= acc_sum;
					end
					m_q <= m_q << 1;
					s_q <= s_q >> 1;
				end
				IT_DIV: begin
					w_q <= fits ? diff : rem_shift;
					q_q <= {q_q[QUO_W-2:0], fits};
					s_q <= s_q << 1;
				end
				IT_SQRT: begin
					w_q <= fits ? diff : rem_shift;
					q_q <= {q_q[QUO_W-2:0], fits};
					s_q <= s_q << 2;
				end
				default: begin
					w_q <= w_q;
				end
			endcase
		end
	end

	assign done = done_q;
	assign work = w_q;
	assign quo  = q_q;

endmodule

>>> hw/rtl/cmm_dp.sv
module cmm_dp import cmm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cmm_cmd_t          cmd,
	output cmm_sts_t          sts,
	input  logic [FRAC_W-1:0] pred_score,
	input  logic              pred_is_bool,
	input  logic              pred_bool,
	input  logic [FRAC_W-1:0] label_score,
	input  logic              label_is_bool,
	input  logic              label_bool,
	input  logic              label_present,
	input  logic              cfg_write,
	input  logic              cfg_index,
	input  logic [FRAC_W-1:0] cfg_data,
	output cmm_result_t       result
);

	logic [FRAC_W-1:0] thr_q;
	score_sel_t        sel_q;
	logic [CNT_W-1:0]  tp_q, fp_q, fn_q, tn_q;

	logic [SCORE_W-1:0]   acc_q, prec_q, rec_q, spec_q, f1_q, hs_q, root_q;
	logic [2*SCORE_W-1:0] rs_q;
	logic [MAG_W-1:0]     ad_q, bc_q;
	logic [PROD_W-1:0]    p1_q, p2_q;
	logic [DEN_W-1:0]     den_q;
	logic [2*MAG_W-1:0]   mag2_q;
	logic [QUO_W-1:0]     x_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THRESHOLD_RESET;
			sel_q <= SEL_ACC;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_THRESHOLD: thr_q <= cfg_data;
				CFG_SCORE_SEL: sel_q <= score_sel_t'(cfg_data[1:0]);
				default:       thr_q <= thr_q;
			endcase
		end
	end

	// Classification and saturating counters
	logic pred_pos, label_pos;
	assign pred_pos  = pred_is_bool ? pred_bool : (pred_score >= thr_q);
	assign label_pos = label_is_bool ? label_bool : (label_score > SCORE_HALF);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tp_q <= '0;
			fp_q <= '0;
			fn_q <= '0;
			tn_q <= '0;
		end else if (cmd.accept && label_present) begin
			if (pred_pos && label_pos && (tp_q != '1)) tp_q <= tp_q + CNT_W'(1);
			if (pred_pos && !label_pos && (fp_q != '1)) fp_q <= fp_q + CNT_W'(1);
			if (!pred_pos && label_pos && (fn_q != '1)) fn_q <= fn_q + CNT_W'(1);
			if (!pred_pos && !label_pos && (tn_q != '1)) tn_q <= tn_q + CNT_W'(1);
		end
	end

	// Marginal sums of the matrix
	logic [SUM_W-1:0] total, correct, ppos, pos, neg, pneg, f1_num, f1_den;
	assign total   = SUM_W'(tp_q) + SUM_W'(fp_q) + SUM_W'(fn_q) + SUM_W'(tn_q);
	assign correct = SUM_W'(tp_q) + SUM_W'(tn_q);
	assign ppos    = SUM_W'(tp_q) + SUM_W'(fp_q);
	assign pos     = SUM_W'(tp_q) + SUM_W'(fn_q);
	assign neg     = SUM_W'(fp_q) + SUM_W'(tn_q);
	assign pneg    = SUM_W'(fn_q) + SUM_W'(tn_q);
	assign f1_num  = SUM_W'(tp_q) << 1;
	assign f1_den  = f1_num + SUM_W'(fn_q) + SUM_W'(fp_q);

	// Signed MCC numerator as sign and magnitude
	logic             mcc_neg;
	logic [MAG_W-1:0] mag;
	assign mcc_neg = ad_q < bc_q;
	assign mag     = mcc_neg ? (bc_q - ad_q) : (ad_q - bc_q);

	logic [SCORE_W:0]     ss_sum;
	logic [2*SCORE_W:0]   hs_num;
	assign ss_sum = {1'b0, rec_q} + {1'b0, spec_q};
	assign hs_num = {rs_q, 1'b0};

	// Operand selection for the shared iterative unit
	iter_mode_t         it_mode;
	logic [STEP_W-1:0]  it_steps;
	logic [WORK_W-1:0]  it_w;
	logic [DEN_W-1:0]   it_m;
	logic [SHIFT_W-1:0] it_s;
	logic [SUM_W-1:0]   r_num, r_den;
	logic               it_done;
	logic [WORK_W-1:0]  it_work;
	logic [QUO_W-1:0]   it_quo;

	always_comb begin
		r_num = '0;
		r_den = '0;
		case (cmd.op)
			OP_ACC:  begin r_num = correct; r_den = total;  end
			OP_PREC: begin r_num = SUM_W'(tp_q); r_den = ppos; end
			OP_REC:  begin r_num = SUM_W'(tp_q); r_den = pos;  end
			OP_SPEC: begin r_num = SUM_W'(tn_q); r_den = neg;  end
			OP_F1:   begin r_num = f1_num; r_den = f1_den; end
			default: begin r_num = '0; r_den = '0; end
		endcase
	end

	always_comb begin
		it_mode  = IT_DIV;
		it_steps = STEP_W'(FRAC_W);
		it_w     = WORK_W'(r_num);
		it_m     = DEN_W'(r_den);
		it_s     = '0;
		case (cmd.op)
			OP_RS: begin
				it_mode  = IT_MUL;
				it_steps = STEP_W'(SCORE_W);
				it_w     = '0;
				it_m     = DEN_W'(rec_q);
				it_s     = SHIFT_W'(spec_q);
			end
			OP_HS: begin
				it_steps = STEP_W'(SCORE_W);
				it_w     = WORK_W'(hs_num >> SCORE_W);
				it_m     = DEN_W'(ss_sum);
				it_s     = SHIFT_W'(hs_num[SCORE_W-1:0]) << (SHIFT_W - SCORE_W);
			end
			OP_AD: begin
				it_mode  = IT_MUL;
				it_steps = STEP_W'(CNT_W);
				it_w     = '0;
				it_m     = DEN_W'(tp_q);
				it_s     = SHIFT_W'(tn_q);
			end
			OP_BC: begin
				it_mode  = IT_MUL;
				it_steps = STEP_W'(CNT_W);
				it_w     = '0;
				it_m     = DEN_W'(fp_q);
				it_s     = SHIFT_W'(fn_q);
			end
			OP_P1: begin
				it_mode  = IT_MUL;
				it_steps = STEP_W'(PAIR_W);
				it_w     = '0;
				it_m     = DEN_W'(pos);
				it_s     = SHIFT_W'(neg);
			end
			OP_P2: begin
				it_mode  = IT_MUL;
				it_steps = STEP_W'(PAIR_W);
				it_w     = '0;
				it_m     = DEN_W'(ppos);
				it_s     = SHIFT_W'(pneg);
			end
			OP_DEN: begin
				it_mode  = IT_MUL;
				it_steps = STEP_W'(PROD_W);
				it_w     = '0;
				it_m     = DEN_W'(p1_q);
				it_s     = p2_q;
			end
			OP_MAG2: begin
				it_mode  = IT_MUL;
				it_steps = STEP_W'(MAG_W);
				it_w     = '0;
				it_m     = DEN_W'(mag);
				it_s     = SHIFT_W'(mag);
			end
			OP_X: begin
				// Dividend is the squared numerator shifted up by twice the fraction.
				it_steps = STEP_W'(QUO_W);
				it_w     = WORK_W'(mag2_q >> 1);
				it_m     = den_q;
				it_s     = {mag2_q[0], {(SHIFT_W-1){1'b0}}};
			end
			OP_SQRT: begin
				it_mode  = IT_SQRT;
				it_steps = STEP_W'(SCORE_W);
				it_w     = '0;
				it_m     = '0;
				it_s     = SHIFT_W'(x_q) << (SHIFT_W - 2*SCORE_W);
			end
			default: begin
				it_mode = IT_DIV;
			end
		endcase
	end

	cmm_iter u_iter (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.start),
		.mode   (it_mode),
		.steps  (it_steps),
		.w_init (it_w),
		.m_init (it_m),
		.s_init (it_s),
		.done   (it_done),
		.work   (it_work),
		.quo    (it_quo)
	);

	assign sts.done = it_done;

	// Ratio with its special cases: empty denominator and a full ratio
	logic [SCORE_W-1:0] ratio_val;
	always_comb begin
		if (r_den == '0) begin
			ratio_val = (cmd.op == OP_F1) ? SCORE_ONE : '0;
		end else if (r_num >= r_den) begin
			ratio_val = SCORE_ONE;
		end else begin
			ratio_val = SCORE_W'(it_quo[FRAC_W-1:0]);
		end
	end

	// Capture the finished operation
	always_ff @(posedge clk) begin
		if (it_done) begin
			case (cmd.op)
				OP_ACC:  acc_q  <= ratio_val;
				OP_PREC: prec_q <= ratio_val;
				OP_REC:  rec_q  <= ratio_val;
				OP_SPEC: spec_q <= ratio_val;
				OP_F1:   f1_q   <= ratio_val;
				OP_RS:   rs_q   <= it_work[2*SCORE_W-1:0];
				OP_HS:   hs_q   <= (ss_sum < TINY_SUM) ? '0 : it_quo[SCORE_W-1:0];
				OP_AD:   ad_q   <= it_work[MAG_W-1:0];
				OP_BC:   bc_q   <= it_work[MAG_W-1:0];
				OP_P1:   p1_q   <= it_work[PROD_W-1:0];
				OP_P2:   p2_q   <= it_work[PROD_W-1:0];
				OP_DEN:  den_q  <= it_work[DEN_W-1:0];
				OP_MAG2: mag2_q <= it_work[2*MAG_W-1:0];
				OP_X:    x_q    <= it_quo;
				OP_SQRT: root_q <= it_quo[SCORE_W-1:0];
				default: acc_q  <= acc_q;
			endcase
		end
	end

	// MCC output and loss
	logic               den_zero, m_neg;
	logic [SCORE_W-1:0] m_mag, qm;
	logic [MCC_W-1:0]   mcc_out;
	logic [SCORE_W:0]   loss_raw;
	logic [SCORE_W-1:0] sel_score;

	always_comb begin
		den_zero = den_q == '0;
		m_mag    = den_zero ? '0 : root_q;
		m_neg    = !den_zero && mcc_neg;
		qm       = m_mag >> (FRAC_W - MCC_FRAC);
		if (m_neg) begin
			mcc_out = -MCC_W'(qm);
		end else if (qm > SCORE_W'(MCC_MAX)) begin
			mcc_out = MCC_MAX;
		end else begin
			mcc_out = MCC_W'(qm);
		end

		case (sel_q)
			SEL_ACC: sel_score = acc_q;
			SEL_F1:  sel_score = f1_q;
			default: sel_score = hs_q;
		endcase

		if (sel_q == SEL_MCC) begin
			loss_raw = m_neg ? ({1'b0, SCORE_ONE} + {1'b0, m_mag})
			                 : ({1'b0, SCORE_ONE} - {1'b0, m_mag});
		end else if (sel_score >= SCORE_ONE) begin
			loss_raw = '0;
		end else begin
			loss_raw = {1'b0, SCORE_ONE} - {1'b0, sel_score};
		end
	end

	always_comb begin
		result.true_pos        = tp_q;
		result.false_pos       = fp_q;
		result.false_neg       = fn_q;
		result.true_neg        = tn_q;
		result.accuracy        = sat_score({1'b0, acc_q});
		result.precision       = sat_score({1'b0, prec_q});
		result.recall          = sat_score({1'b0, rec_q});
		result.specificity     = sat_score({1'b0, spec_q});
		result.f1_score        = sat_score({1'b0, f1_q});
		result.mcc             = mcc_out;
		result.sens_spec_score = sat_score({1'b0, hs_q});
		result.loss            = sat_score(loss_raw);
	end

endmodule

>>> hw/rtl/cmm_ctrl.sv
module cmm_ctrl import cmm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  logic     out_ready,
	output logic     out_valid,
	output cmm_cmd_t cmd,
	input  cmm_sts_t sts
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_ISSUE = 4'b0010,
		ST_WAIT  = 4'b0100,
		ST_HOLD  = 4'b1000
	} state_t;

	state_t state_q;
	op_t    op_q;
	logic   out_valid_q;

	// Command decode
	always_comb begin
		cmd.accept = in_valid && (state_q == ST_IDLE);
		cmd.start  = state_q == ST_ISSUE;
		cmd.op     = op_q;
		cmd.load   = (state_q == ST_HOLD) && (!out_valid_q || out_ready);
	end

	// Sequencer over the micro-operations
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= OP_FIRST;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.accept) begin
						op_q    <= OP_FIRST;
						state_q <= ST_ISSUE;
					end
				end
				ST_ISSUE: state_q <= ST_WAIT;
				ST_WAIT: begin
					if (sts.done) begin
						if (op_q == OP_LAST) begin
							state_q <= ST_HOLD;
						end else begin
							op_q    <= op_t'(op_q + 1'b1);
							state_q <= ST_ISSUE;
						end
					end
				end
				ST_HOLD: begin
					if (cmd.load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Output register occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign in_ready  = state_q == ST_IDLE;
	assign out_valid = out_valid_q;

endmodule
